// ===== sv/hbq_pkg.sv =====
// hbq_pkg: shared types, codes and constants of the binary max-heap queue
// used by hbq_cmp, hbq_sift and binary_max_heap_queue_unit
`timescale 1ns / 1ps
`default_nettype none

package hbq_pkg;

  localparam int VALUE_W        = 32;
  localparam int COUNT_W        = 11;
  localparam int CAP_W          = 11;
  localparam int HEAP_DEPTH_DEF = 1024;

  localparam logic [CAP_W-1:0] CAP_RESET = 11'd1024;

  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_DELETE = 1'b1;

  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_FULL_REJ  = 2'd1;
  localparam logic [1:0] STATUS_EMPTY_REJ = 2'd2;

  typedef struct packed {
    logic                      command;
    logic signed [VALUE_W-1:0] value;
  } cmd_item_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0] top_value;
    logic [COUNT_W-1:0]        entry_count;
    logic                      is_empty;
    logic                      is_full;
    logic [1:0]                status;
  } res_item_t;

  // start request from the front end to the sift sequencer
  typedef struct packed {
    logic                      start;
    logic                      command;
    logic signed [VALUE_W-1:0] value;
  } sift_req_t;

  typedef enum logic [1:0] {
    T_IDLE,
    T_RUN,
    T_DONE
  } top_state_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_UP_CHK,
    S_UP_CMP,
    S_DN_LAST,
    S_DN_CHK,
    S_DN_SEL,
    S_DN_CMP
  } sift_state_t;

endpackage

`default_nettype wire

// ===== sv/hbq_cmp.sv =====
// hbq_cmp: the shared signed magnitude comparator of the sift sequencer
// depends on hbq_pkg for the value width
`timescale 1ns / 1ps
`default_nettype none

module hbq_cmp (
  input  wire logic signed [hbq_pkg::VALUE_W-1:0] a,
  input  wire logic signed [hbq_pkg::VALUE_W-1:0] b,
  output logic                                    gt
);
  import hbq_pkg::*;

  assign gt = (a > b);

endmodule

`default_nettype wire

// ===== sv/hbq_mem.sv =====
// hbq_mem: heap entry store, one write port and two registered read ports
// depends on nothing but its parameters
`timescale 1ns / 1ps
`default_nettype none

module hbq_mem #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_a,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic      [WIDTH-1:0]         rdata_a,
  output logic      [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

`default_nettype wire

// ===== sv/hbq_sift.sv =====
// hbq_sift: sequencer that runs sift-up and sift-down over the entry store
// depends on hbq_pkg, hbq_cmp and hbq_mem
`timescale 1ns / 1ps
`default_nettype none

module hbq_sift #(
  parameter int HEAP_DEPTH = hbq_pkg::HEAP_DEPTH_DEF
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire hbq_pkg::sift_req_t                    req,
  output logic                                       done,
  output logic        [$clog2(HEAP_DEPTH+1)-1:0]     count,
  output logic signed [hbq_pkg::VALUE_W-1:0]         root
);
  import hbq_pkg::*;

  localparam int CNT_W  = $clog2(HEAP_DEPTH + 1);
  localparam int ADDR_W = $clog2(HEAP_DEPTH);

  sift_state_t state, state_next;

  logic [CNT_W-1:0]          count_next;
  logic [CNT_W-1:0]          hole, hole_next;
  logic [CNT_W-1:0]          cidx, cidx_next;
  logic signed [VALUE_W-1:0] cur, cur_next;
  logic signed [VALUE_W-1:0] child, child_next;

  logic [CNT_W:0]            c2;
  logic [CNT_W:0]            rd_slot_a, rd_slot_b;
  logic [CNT_W:0]            wr_slot;

  logic                      mem_we;
  logic signed [VALUE_W-1:0] mem_wdata;
  logic [VALUE_W-1:0]        rdata_a, rdata_b;

  logic signed [VALUE_W-1:0] cmp_a, cmp_b;
  logic                      gt;

  assign c2      = {hole, 1'b0};
  assign wr_slot = {1'b0, hole};

  hbq_cmp u_cmp (
    .a  (cmp_a),
    .b  (cmp_b),
    .gt (gt)
  );

  // slot s of the 1-based heap lives at address s-1
  hbq_mem #(
    .DEPTH (HEAP_DEPTH),
    .WIDTH (VALUE_W)
  ) u_mem (
    .clk     (clk),
    .we      (mem_we),
    .waddr   (ADDR_W'(wr_slot - 1'b1)),
    .wdata   (mem_wdata),
    .raddr_a (ADDR_W'(rd_slot_a - 1'b1)),
    .raddr_b (ADDR_W'(rd_slot_b - 1'b1)),
    .rdata_a (rdata_a),
    .rdata_b (rdata_b)
  );

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (req.start) begin
          state_next = (req.command == CMD_INSERT) ? S_UP_CHK : S_DN_LAST;
        end
      end
      S_UP_CHK: begin
        state_next = (hole == CNT_W'(1)) ? S_IDLE : S_UP_CMP;
      end
      S_UP_CMP: begin
        state_next = gt ? S_UP_CHK : S_IDLE;
      end
      S_DN_LAST: begin
        state_next = (count == '0) ? S_IDLE : S_DN_CHK;
      end
      S_DN_CHK: begin
        state_next = (c2 > {1'b0, count}) ? S_IDLE : S_DN_SEL;
      end
      S_DN_SEL: begin
        state_next = S_DN_CMP;
      end
      S_DN_CMP: begin
        state_next = gt ? S_IDLE : S_DN_CHK;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_comb begin
    count_next = count;
    hole_next  = hole;
    cidx_next  = cidx;
    cur_next   = cur;
    child_next = child;
    rd_slot_a  = c2;
    rd_slot_b  = c2 + 1'b1;
    mem_we     = 1'b0;
    mem_wdata  = cur;
    cmp_a      = cur;
    cmp_b      = $signed(rdata_a);
    done       = 1'b0;
    case (state)
      S_IDLE: begin
        if (req.start) begin
          hole_next = CNT_W'(1);
          cur_next  = req.value;
          if (req.command == CMD_INSERT) begin
            count_next = count + 1'b1;
            hole_next  = count + 1'b1;
          end else begin
            count_next = count - 1'b1;
            rd_slot_a  = {1'b0, count};
          end
        end
      end
      S_UP_CHK: begin
        rd_slot_a = {2'b00, hole[CNT_W-1:1]};
        if (hole == CNT_W'(1)) begin
          mem_we = 1'b1;
          done   = 1'b1;
        end
      end
      S_UP_CMP: begin
        mem_we = 1'b1;
        if (gt) begin
          mem_wdata = $signed(rdata_a);
          hole_next = {1'b0, hole[CNT_W-1:1]};
        end else begin
          done = 1'b1;
        end
      end
      S_DN_LAST: begin
        cur_next = $signed(rdata_a);
        if (count == '0) begin
          done = 1'b1;
        end
      end
      S_DN_CHK: begin
        if (c2 > {1'b0, count}) begin
          mem_we = 1'b1;
          done   = 1'b1;
        end
      end
      S_DN_SEL: begin
        // right child wins only when it exists and is strictly larger
        cmp_a = $signed(rdata_b);
        cmp_b = $signed(rdata_a);
        if (((c2 + 1'b1) <= {1'b0, count}) && gt) begin
          child_next = $signed(rdata_b);
          cidx_next  = CNT_W'(c2 + 1'b1);
        end else begin
          child_next = $signed(rdata_a);
          cidx_next  = CNT_W'(c2);
        end
      end
      S_DN_CMP: begin
        cmp_b  = child;
        mem_we = 1'b1;
        if (gt) begin
          done = 1'b1;
        end else begin
          mem_wdata = child;
          hole_next = cidx;
        end
      end
      default: begin
        done = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
    end
    hole  <= hole_next;
    cidx  <= cidx_next;
    cur   <= cur_next;
    child <= child_next;
    // the root is shadowed so the result needs no extra read
    if (mem_we && (hole == CNT_W'(1))) begin
      root <= mem_wdata;
    end
  end

`ifndef SYNTHESIS
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(HEAP_DEPTH))
    else $error("heap count above depth");

  a_start_idle: assert property (@(posedge clk) disable iff (rst)
    req.start |-> (state == S_IDLE))
    else $error("sift start while busy");

  a_write_slot: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> ((hole != '0) && (hole <= count)))
    else $error("store write outside live slots");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |=> (state == S_IDLE))
    else $error("sequencer busy after done");
`endif

endmodule

`default_nettype wire

// ===== sv/binary_max_heap_queue_unit.sv =====
// binary_max_heap_queue_unit: max-heap priority queue top level
// front end, capacity register and result register; depends on hbq_pkg, hbq_sift
//
// Usage: each request on the cmd channel (valid/ready) is an insert of a signed
// value or a delete of the maximum. Every request yields exactly one result on
// the res channel (valid/ready): maximum after the request (0 when empty),
// entry count, empty and full flags, and a status (ok, insert rejected full,
// delete rejected empty). A rejected request leaves the heap unchanged.
// cfg_we writes the capacity limit (capacity above the store depth acts as
// the depth); write it only while no request is in flight.
// A rejected request goes straight to the result register; an insert moves the
// new value up one level at a time until it reaches the root or a parent that
// is not smaller; a delete that leaves entries moves the last entry to the root
// and down one level at a time until it is larger than its larger child or is
// at a leaf. One request at a time: the next one is accepted the cycle after
// the result is registered, even while the receiver stalls; a finished result
// waits until the result register is free. Reset empties the heap and sets the
// capacity limit to 1024; the store itself is not cleared.
`timescale 1ns / 1ps
`default_nettype none

module binary_max_heap_queue_unit #(
  parameter int HEAP_DEPTH = hbq_pkg::HEAP_DEPTH_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        cmd_valid,
  output logic                             cmd_ready,
  input  wire hbq_pkg::cmd_item_t          cmd_item,
  output logic                             res_valid,
  input  wire logic                        res_ready,
  output hbq_pkg::res_item_t               res_item,
  input  wire logic                        cfg_we,
  input  wire logic [hbq_pkg::CAP_W-1:0]   cfg_wdata
);
  import hbq_pkg::*;

  localparam int CNT_W = $clog2(HEAP_DEPTH + 1);
  localparam int CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;

  top_state_t state, state_next;

  logic [CAP_W-1:0]          cap;
  logic [1:0]                status;
  logic [1:0]                status_next;
  logic                      accept;
  logic                      reject;
  logic                      full_now;
  logic                      out_free;
  logic                      sift_done;
  logic [CNT_W-1:0]          count;
  logic signed [VALUE_W-1:0] root;
  sift_req_t                 sift_req;

  assign accept   = cmd_valid && cmd_ready;
  assign out_free = !res_valid || res_ready;
  assign full_now = (CMP_W'(count) >= CMP_W'(cap)) || (count >= CNT_W'(HEAP_DEPTH));

  always_comb begin
    reject      = 1'b0;
    status_next = STATUS_OK;
    if (cmd_item.command == CMD_INSERT) begin
      if (full_now) begin
        reject      = 1'b1;
        status_next = STATUS_FULL_REJ;
      end
    end else if (count == '0) begin
      reject      = 1'b1;
      status_next = STATUS_EMPTY_REJ;
    end
  end

  hbq_sift #(
    .HEAP_DEPTH (HEAP_DEPTH)
  ) u_sift (
    .clk   (clk),
    .rst   (rst),
    .req   (sift_req),
    .done  (sift_done),
    .count (count),
    .root  (root)
  );

  always_comb begin
    state_next = state;
    case (state)
      T_IDLE: begin
        if (accept) begin
          state_next = reject ? T_DONE : T_RUN;
        end
      end
      T_RUN: begin
        if (sift_done) begin
          state_next = T_DONE;
        end
      end
      T_DONE: begin
        if (out_free) begin
          state_next = T_IDLE;
        end
      end
      default: begin
        state_next = T_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd_ready        = (state == T_IDLE);
    sift_req.start   = accept && !reject;
    sift_req.command = cmd_item.command;
    sift_req.value   = cmd_item.value;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= T_IDLE;
      cap       <= CAP_RESET;
      res_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        cap <= cfg_wdata;
      end
      if ((state == T_DONE) && out_free) begin
        res_valid <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
    end
    if (accept) begin
      status <= status_next;
    end
    if ((state == T_DONE) && out_free) begin
      res_item.top_value   <= (count == '0) ? '0 : root;
      res_item.entry_count <= COUNT_W'(count);
      res_item.is_empty    <= (count == '0);
      res_item.is_full     <= full_now;
      res_item.status      <= status;
    end
  end

endmodule

`default_nettype wire

// ===== tb/tb_binary_max_heap_queue_unit.sv =====
// self-checking bench for binary_max_heap_queue_unit: insert and delete-max requests
// checked against a behavioral max-heap kept in the bench; depends on hbq_pkg
`timescale 1ns / 1ps

module tb_binary_max_heap_queue_unit;
  import hbq_pkg::*;

  localparam int DEPTH = HEAP_DEPTH_DEF;

  logic                 clk;
  logic                 rst;
  logic                 cmd_valid;
  logic                 cmd_ready;
  cmd_item_t            cmd_item;
  logic                 res_valid;
  logic                 res_ready;
  res_item_t            res_item;
  logic                 cfg_we;
  logic [CAP_W-1:0]     cfg_wdata;

  binary_max_heap_queue_unit uut (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd_item  (cmd_item),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res_item  (res_item),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  // behavioral heap, 1-based like the block's store
  logic signed [VALUE_W-1:0] heap_vals [1:DEPTH];
  int unsigned               heap_size;
  int unsigned               heap_cap;

  cmd_item_t   req_backlog[$];
  res_item_t   heap_answers[$];

  int unsigned queued_total;
  int unsigned accepted_total;
  int unsigned results_seen;
  int unsigned bad_count;
  int unsigned full_rejects;
  int unsigned empty_rejects;
  int unsigned peak_size;
  int unsigned cap_settings;

  // sender and receiver shaping
  logic        req_taken;
  int unsigned gap_left;
  int unsigned burst_left;
  int unsigned gap_max;
  logic        stall_on;
  logic [31:0] ready_pat;
  int unsigned hold_gen;
  int unsigned hold_seen;
  int unsigned hold_left;

  always #6 clk = ~clk;

  function automatic res_item_t heap_step(cmd_item_t req);
    int unsigned               lim;
    int unsigned               idx;
    int unsigned               kid;
    logic                      done;
    logic signed [VALUE_W-1:0] tmp;
    res_item_t                 r;
    lim = (heap_cap > DEPTH) ? DEPTH : heap_cap;
    r.status = STATUS_OK;
    if (req.command == CMD_INSERT) begin
      if (heap_size >= lim) begin
        r.status = STATUS_FULL_REJ;
      end else begin
        heap_size++;
        heap_vals[heap_size] = req.value;
        idx = heap_size;
        while (idx > 1 && heap_vals[idx] > heap_vals[idx / 2]) begin
          tmp = heap_vals[idx];
          heap_vals[idx] = heap_vals[idx / 2];
          heap_vals[idx / 2] = tmp;
          idx = idx / 2;
        end
      end
    end else begin
      if (heap_size == 0) begin
        r.status = STATUS_EMPTY_REJ;
      end else begin
        heap_vals[1] = heap_vals[heap_size];
        heap_size--;
        idx = 1;
        done = 1'b0;
        // ties go to the left child, and the parent moves down on equal
        while (!done && 2 * idx <= heap_size) begin
          kid = 2 * idx;
          if (kid + 1 <= heap_size && heap_vals[kid] < heap_vals[kid + 1]) kid = kid + 1;
          if (heap_vals[idx] <= heap_vals[kid]) begin
            tmp = heap_vals[idx];
            heap_vals[idx] = heap_vals[kid];
            heap_vals[kid] = tmp;
            idx = kid;
          end else begin
            done = 1'b1;
          end
        end
      end
    end
    r.top_value   = (heap_size == 0) ? '0 : heap_vals[1];
    r.entry_count = COUNT_W'(heap_size);
    r.is_empty    = (heap_size == 0);
    r.is_full     = (heap_size >= lim);
    return r;
  endfunction

  function automatic cmd_item_t rand_req(int unsigned ins_pct);
    cmd_item_t   r;
    int unsigned pick;
    r.command = ($urandom_range(99) < ins_pct) ? CMD_INSERT : CMD_DELETE;
    pick = $urandom_range(99);
    if (pick < 25) begin
      // narrow range so ties between parent and children show up
      r.value = int'($urandom_range(6)) - 3;
    end else if (pick < 35) begin
      case ($urandom_range(3))
        0: r.value = 32'sh7fff_ffff;
        1: r.value = 32'sh8000_0000;
        2: r.value = '0;
        default: r.value = '1;
      endcase
    end else begin
      r.value = $urandom;
    end
    return r;
  endfunction

  task automatic push_req(logic cmd, logic signed [VALUE_W-1:0] val);
    cmd_item_t r;
    r.command = cmd;
    r.value   = val;
    req_backlog.push_back(r);
    queued_total++;
  endtask

  task automatic wait_idle();
    while (accepted_total != queued_total || heap_answers.size() != 0) @(negedge clk);
    // margin for the sequencer to settle before touching the capacity
    repeat (40) @(negedge clk);
  endtask

  task automatic run_phase(int unsigned cap, logic fill_up, int unsigned n_rand,
                           int unsigned ins_pct, int unsigned gaps, logic stalls,
                           logic long_hold);
    int unsigned n_fill;
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= CAP_W'(cap);
    heap_cap = cap;
    cap_settings++;
    @(negedge clk);
    cfg_we  <= 1'b0;
    gap_max  = gaps;
    stall_on = stalls;
    n_fill = fill_up ? (DEPTH - heap_size + 6) : 0;
    repeat (n_fill) push_req(CMD_INSERT, $urandom);
    repeat (n_rand) begin
      req_backlog.push_back(rand_req(ins_pct));
      queued_total++;
    end
    if (long_hold) hold_gen++;
    wait_idle();
  endtask

  // driver: bursts of requests with random gaps
  always @(negedge clk) begin
    if (!rst && (!cmd_valid || req_taken)) begin
      if (gap_left > 0) begin
        gap_left  <= gap_left - 1;
        cmd_valid <= 1'b0;
      end else if (req_backlog.size() > 0) begin
        cmd_item  <= req_backlog.pop_front();
        cmd_valid <= 1'b1;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 12);
          gap_left   <= (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        cmd_valid <= 1'b0;
      end
    end
  end

  // receiver: rotating ready pattern, plus a long hold-off on request
  always @(negedge clk) begin
    if (hold_gen != hold_seen) begin
      hold_seen <= hold_gen;
      hold_left <= 400;
      res_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      res_ready <= 1'b0;
    end else if (!stall_on) begin
      res_ready <= 1'b1;
    end else begin
      res_ready <= ready_pat[0];
      if ($urandom_range(63) == 0) ready_pat <= $urandom | $urandom;
      else ready_pat <= {ready_pat[0], ready_pat[31:1]};
    end
  end

  // prediction on accepted requests, checking on accepted results
  always @(posedge clk) begin : check_blk
    res_item_t want;
    if (rst) begin
      req_taken <= 1'b0;
    end else begin
      req_taken <= cmd_valid && cmd_ready;
      if (cmd_valid && cmd_ready) begin
        want = heap_step(cmd_item);
        heap_answers.push_back(want);
        accepted_total++;
        if (want.status == STATUS_FULL_REJ) full_rejects++;
        if (want.status == STATUS_EMPTY_REJ) empty_rejects++;
        if (heap_size > peak_size) peak_size = heap_size;
      end
      if (res_valid && res_ready) begin
        results_seen++;
        if (heap_answers.size() == 0) begin
          bad_count++;
          if (bad_count <= 10)
            $display("%0t: result with nothing pending: top=%0d cnt=%0d st=%0d",
                     $realtime, res_item.top_value, res_item.entry_count, res_item.status);
        end else begin
          want = heap_answers.pop_front();
          if (res_item.top_value !== want.top_value || res_item.entry_count !== want.entry_count ||
              res_item.is_empty !== want.is_empty || res_item.is_full !== want.is_full ||
              res_item.status !== want.status) begin
            bad_count++;
            if (bad_count <= 10) begin
              $display("%0t: result %0d got top=%0d cnt=%0d empty=%0b full=%0b st=%0d",
                       $realtime, results_seen, res_item.top_value, res_item.entry_count,
                       res_item.is_empty, res_item.is_full, res_item.status);
              $display("    expected top=%0d cnt=%0d empty=%0b full=%0b st=%0d",
                       want.top_value, want.entry_count, want.is_empty, want.is_full,
                       want.status);
            end
          end
        end
      end
    end
  end

  initial begin
    #10_000_000;
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    clk        = 1'b0;
    rst        = 1'b1;
    cmd_valid  = 1'b0;
    cmd_item   = '0;
    res_ready  = 1'b0;
    cfg_we     = 1'b0;
    cfg_wdata  = '0;
    heap_size  = 0;
    heap_cap   = CAP_RESET;
    gap_left   = 0;
    burst_left = 0;
    gap_max    = 0;
    stall_on   = 1'b0;
    ready_pat  = 32'hffff_ffff;
    hold_gen   = 0;
    hold_seen  = 0;
    hold_left  = 0;
    queued_total   = 0;
    accepted_total = 0;
    results_seen   = 0;
    bad_count      = 0;
    full_rejects   = 0;
    empty_rejects  = 0;
    peak_size      = 0;
    cap_settings   = 0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: empty delete, value extremes, ties at the root, drain past empty
    push_req(CMD_DELETE, 32'sd0);
    push_req(CMD_INSERT, 32'sd0);
    push_req(CMD_INSERT, 32'sh7fff_ffff);
    push_req(CMD_INSERT, 32'sh8000_0000);
    push_req(CMD_INSERT, -32'sd1);
    push_req(CMD_INSERT, 32'sh7fff_ffff);
    push_req(CMD_INSERT, 32'sd5);
    push_req(CMD_INSERT, 32'sd5);
    push_req(CMD_INSERT, 32'sh8000_0000);
    repeat (8) push_req(CMD_DELETE, 32'sh7fff_ffff);
    push_req(CMD_DELETE, -32'sd1);
    push_req(CMD_INSERT, -32'sd1);
    push_req(CMD_INSERT, 32'sd1);
    push_req(CMD_DELETE, 32'sd0);
    push_req(CMD_DELETE, 32'sd0);
    push_req(CMD_DELETE, 32'sd0);
    wait_idle();

    run_phase(1,    1'b0, 60,  50, 0, 1'b1, 1'b0);
    run_phase(0,    1'b0, 12,  60, 4, 1'b0, 1'b0);
    run_phase(7,    1'b0, 150, 55, 6, 1'b1, 1'b0);
    run_phase(100,  1'b0, 250, 60, 8, 1'b1, 1'b1);
    // capacity dropped under the current occupancy
    run_phase(3,    1'b0, 80,  40, 3, 1'b1, 1'b0);
    // capacity above the store depth, filled until inserts bounce
    run_phase(2047, 1'b1, 40,  50, 0, 1'b0, 1'b0);
    run_phase(1024, 1'b0, 60,  30, 5, 1'b1, 1'b1);

    $display("checked %0d results from %0d requests over %0d capacity settings",
             results_seen, accepted_total, cap_settings);
    $display("peak occupancy %0d, %0d inserts refused full, %0d deletes refused empty",
             peak_size, full_rejects, empty_rejects);
    if (bad_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("%0d mismatches", bad_count);
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
